/* rtl/core/sgc_pkg.sv */
// shared types, codes and helpers for the signed golomb codec
// no dependencies

package sgc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS    = 5;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNSET = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // one item as it moves down the divider row
  typedef struct packed {
    logic                     cmd;
    logic                     unset;
    logic [SAMPLE_BITS-1:0]   m;
    logic [LEN_BITS-1:0]      b;
    logic [SAMPLE_BITS-1:0]   t;
    logic [SAMPLE_BITS-1:0]   n;     // dividend, left aligned, consumed msb first
    logic [SAMPLE_BITS-1:0]   rem;
    logic [SAMPLE_BITS-1:0]   quo;
    logic [PROD_BITS-1:0]     prod;  // decode: quotient times divisor
    logic [SAMPLE_BITS-1:0]   rdec;  // decode: remainder recovered from its code
  } stage_t;

  // b = ceil(log2 m), i.e. bit length of m-1
  function automatic logic [LEN_BITS-1:0] ceil_log2(input logic [SAMPLE_BITS-1:0] m);
    logic [SAMPLE_BITS-1:0] x;
    logic [LEN_BITS-1:0]    b;
    x = m - 1'b1;
    b = '0;
    if (m > 16'd1) begin
      for (int i = 0; i < SAMPLE_BITS; i++) begin
        if (x[i]) b = LEN_BITS'(i + 1);
      end
    end
    return b;
  endfunction

  // t = 2^b - m
  function automatic logic [SAMPLE_BITS-1:0] trunc_gap(input logic [SAMPLE_BITS-1:0] m,
                                                       input logic [LEN_BITS-1:0] b);
    logic [SAMPLE_BITS:0] full;
    full = (17'd1 << b) - {1'b0, m};
    return full[SAMPLE_BITS-1:0];
  endfunction

endpackage

/* rtl/core/sgc_front.sv */
// divisor register and entry stage: zigzag fold, decode product and remainder
// depends on sgc_pkg

module sgc_front #(
  parameter int W = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic signed [sgc_pkg::SAMPLE_BITS-1:0] signed_value,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]     quotient_in,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]     remainder_code_in,
  output logic                                stage_valid,
  output sgc_pkg::stage_t                     stage_data,
  input  logic                                stage_ready
);
  import sgc_pkg::*;

  logic [SAMPLE_BITS-1:0] divisor;
  logic [LEN_BITS-1:0]    div_b;
  logic [SAMPLE_BITS-1:0] div_t;

  logic [W-1:0]           raw;
  logic [W-1:0]           n_w;
  stage_t                 entry;

  // b and t are taken at the same edge as the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= '0;
      div_b   <= '0;
      div_t   <= '0;
    end else if (cfg_valid) begin
      divisor <= cfg_data;
      div_b   <= ceil_log2(cfg_data);
      div_t   <= trunc_gap(cfg_data, ceil_log2(cfg_data));
    end
  end

  assign in_ready = !stage_valid || stage_ready;

  always_comb begin
    raw = signed_value[W-1:0];
    // zigzag: 2v for v >= 0, -2v-1 for v < 0
    n_w = {raw[W-2:0], 1'b0} ^ {W{raw[W-1]}};

    entry       = '0;
    entry.cmd   = cmd;
    entry.unset = (divisor == '0);
    entry.m     = divisor;
    entry.b     = div_b;
    entry.t     = div_t;
    entry.n     = SAMPLE_BITS'(n_w) << (SAMPLE_BITS - W);
    entry.prod  = quotient_in * divisor;
    entry.rdec  = (remainder_code_in >= div_t) ? remainder_code_in - div_t
                                                : remainder_code_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data <= entry;
    end
  end

endmodule

/* rtl/core/sgc_div_cell.sv */
// one restoring division step: one quotient bit per cell
// depends on sgc_pkg

module sgc_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  sgc_pkg::stage_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output sgc_pkg::stage_t dn_data,
  input  logic            dn_ready
);
  import sgc_pkg::*;

  logic [SAMPLE_BITS:0] rem_sh;
  logic                 fits;
  logic [SAMPLE_BITS:0] rem_sub;
  stage_t               step;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    rem_sh  = {up_data.rem, up_data.n[SAMPLE_BITS-1]};
    fits    = (rem_sh >= {1'b0, up_data.m});
    rem_sub = rem_sh - {1'b0, up_data.m};
    step     = up_data;
    step.n   = up_data.n << 1;
    step.rem = fits ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
    step.quo = {up_data.quo[SAMPLE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= step;
    end
  end

endmodule

/* rtl/core/sgc_finish.sv */
// output stage: truncated binary remainder code, decode sum, range check, unfold
// depends on sgc_pkg

module sgc_finish #(
  parameter int W = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  input  sgc_pkg::stage_t                        up_data,
  output logic                                   up_ready,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             status,
  output logic signed [sgc_pkg::SAMPLE_BITS-1:0] decoded_value,
  output logic [sgc_pkg::SAMPLE_BITS-1:0]        quotient_out,
  output logic [sgc_pkg::SAMPLE_BITS-1:0]        remainder_code_out,
  output logic [sgc_pkg::LEN_BITS-1:0]           remainder_length
);
  import sgc_pkg::*;

  logic [PROD_BITS:0]     n_dec;
  logic [SAMPLE_BITS-1:0] n_lo;
  logic [SAMPLE_BITS:0]   half;
  logic [SAMPLE_BITS:0]   neg;
  logic [1:0]             st_c;
  logic [SAMPLE_BITS-1:0] dec_c;
  logic [SAMPLE_BITS-1:0] quo_c;
  logic [SAMPLE_BITS-1:0] code_c;
  logic [LEN_BITS-1:0]    len_c;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    n_dec = {1'b0, up_data.prod} + (PROD_BITS + 1)'(up_data.rdec);
    n_lo  = n_dec[SAMPLE_BITS-1:0];
    half  = ({1'b0, n_lo} + 1'b1) >> 1;
    neg   = '0 - half;

    st_c   = STAT_OK;
    dec_c  = '0;
    quo_c  = '0;
    code_c = '0;
    len_c  = '0;
    if (up_data.unset) begin
      st_c = STAT_UNSET;
    end else if (up_data.cmd == CMD_ENCODE) begin
      quo_c = up_data.quo;
      if (up_data.rem < up_data.t) begin
        code_c = up_data.rem;
        len_c  = up_data.b - 1'b1;
      end else begin
        code_c = up_data.rem + up_data.t;
        len_c  = up_data.b;
      end
    end else if (n_dec[PROD_BITS:W] != '0) begin
      st_c = STAT_RANGE;
    end else if (n_lo[0]) begin
      dec_c = neg[SAMPLE_BITS-1:0];
    end else begin
      dec_c = {1'b0, n_lo[SAMPLE_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      status             <= st_c;
      decoded_value      <= dec_c;
      quotient_out       <= quo_c;
      remainder_code_out <= code_c;
      remainder_length   <= len_c;
    end
  end

endmodule

/* rtl/core/signed_golomb_codec_unit.sv */
// signed golomb codec: entry stage, a row of division cells, output stage
// registers: entry stage, W division cells, output stage; W = min(VALUE_BITS, 16)
// throughput: one item per cycle while out_ready does not stall the output; the row of W division cells
//   yields one quotient bit per cell, so a new item can enter every cycle unless the row is stalled
// reset: clears all stage valid bits and the divisor (divisor unset)
// depends on sgc_pkg, sgc_front, sgc_div_cell, sgc_finish

module signed_golomb_codec_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   cmd,
  input  logic signed [sgc_pkg::SAMPLE_BITS-1:0] signed_value,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]        quotient_in,
  input  logic [sgc_pkg::SAMPLE_BITS-1:0]        remainder_code_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             status,
  output logic signed [sgc_pkg::SAMPLE_BITS-1:0] decoded_value,
  output logic [sgc_pkg::SAMPLE_BITS-1:0]        quotient_out,
  output logic [sgc_pkg::SAMPLE_BITS-1:0]        remainder_code_out,
  output logic [sgc_pkg::LEN_BITS-1:0]           remainder_length
);
  import sgc_pkg::*;

  localparam int W = (VALUE_BITS < SAMPLE_BITS) ? VALUE_BITS : SAMPLE_BITS;

  logic   row_valid [0:W];
  logic   row_ready [0:W];
  stage_t row_data  [0:W];

  assign cfg_ready = 1'b1;

  sgc_front #(.W(W)) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .signed_value      (signed_value),
    .quotient_in       (quotient_in),
    .remainder_code_in (remainder_code_in),
    .stage_valid       (row_valid[0]),
    .stage_data        (row_data[0]),
    .stage_ready       (row_ready[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    sgc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (row_valid[k]),
      .up_data  (row_data[k]),
      .up_ready (row_ready[k]),
      .dn_valid (row_valid[k+1]),
      .dn_data  (row_data[k+1]),
      .dn_ready (row_ready[k+1])
    );
  end

  sgc_finish #(.W(W)) u_finish (
    .clk                (clk),
    .rst                (rst),
    .up_valid           (row_valid[W]),
    .up_data            (row_data[W]),
    .up_ready           (row_ready[W]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .decoded_value      (decoded_value),
    .quotient_out       (quotient_out),
    .remainder_code_out (remainder_code_out),
    .remainder_length   (remainder_length)
  );

  // unset divisor gives an all-zero item apart from status
  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_UNSET |->
      decoded_value == '0 && quotient_out == '0 && remainder_code_out == '0 &&
      remainder_length == '0)
    else $error("unset divisor item carries nonzero fields");

  // remainder code fits in its stated length
  a_code_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_OK |->
      (32'(remainder_code_out) >> remainder_length) == 32'd0)
    else $error("remainder code wider than its length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_UNSET || status == STAT_RANGE)
    else $error("undefined status code");

  // a range error only comes from decode, so no encode fields go with it
  a_range_decode: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_RANGE |->
      decoded_value == '0 && remainder_length == '0 && quotient_out == '0)
    else $error("range error item carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
